// ===== design/egd_pkg.sv =====
package egd_pkg;

  // Frame geometry and glow border
  localparam int FRAME_WIDTH  = 256;
  localparam int FRAME_HEIGHT = 192;
  localparam int BORDER       = 16;

  // Field widths
  localparam int PIX_W = 16;
  localparam int POS_W = 8;
  localparam int CH_W  = 5;
  localparam logic [CH_W-1:0] CH_MAX = 5'd31;

  localparam int SCALE_W = 5;
  localparam int DARK_W  = CH_W + SCALE_W;

  // Position compare width: wide enough for the frame size and the position field
  localparam int FRAME_MAX = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int SIZE_W    = $clog2(FRAME_MAX) + 1;
  localparam int CMP_W     = (SIZE_W > POS_W) ? SIZE_W : POS_W;

  // Glow weight arithmetic
  localparam int K_W      = $clog2(BORDER + 1);
  localparam int KSQ_W    = 2 * K_W;
  localparam int NUM_W    = CH_W + KSQ_W;
  localparam int DEN      = BORDER * BORDER;
  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = NUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / DEN);

  // Pipeline depth
  localparam int NSTG = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EFFECT_MODE  = 1'b0,
    CFG_DARKEN_SCALE = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    MODE_GLOW   = 1'b0,
    MODE_DARKEN = 1'b1
  } effect_mode_e;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd10;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NSTG-1:0] en;
  } egd_ctl_t;

endpackage

// ===== design/egd_if.sv =====
interface egd_pix_in_if;
  import egd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic [POS_W-1:0] column;
  logic [POS_W-1:0] row;

  modport source (output valid, output pixel_in, output column, output row, input ready);
  modport sink   (input valid, input pixel_in, input column, input row, output ready);
endinterface

interface egd_pix_out_if;
  import egd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, output pixel_out, input ready);
  modport sink   (input valid, input pixel_out, output ready);
endinterface

interface egd_cfg_if;
  import egd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/egd_ctrl.sv =====
module egd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output egd_pkg::egd_ctl_t ctl_o
);
  import egd_pkg::*;

  logic [NSTG-1:0] v_q, v_d;
  logic [NSTG-1:0] en;

  // A stage loads when it is empty or its word moves on this cycle
  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_ready_i;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) begin
        v_d[i] = v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSTG-1];
  assign ctl_o.en    = en;

endmodule

// ===== design/egd_pos.sv =====
module egd_pos (
  input  logic                     clk_i,
  input  egd_pkg::egd_ctl_t        ctl_i,
  input  logic [egd_pkg::POS_W-1:0] column_i,
  input  logic [egd_pkg::POS_W-1:0] row_i,
  output logic [egd_pkg::KSQ_W-1:0] ksq_o
);
  import egd_pkg::*;

  logic [POS_W-1:0] dx_d, dx_q, dy_d, dy_q;
  logic [POS_W-1:0] dmin;
  logic [K_W-1:0]   k_d, k_q;
  logic [KSQ_W-1:0] ksq_d, ksq_q;
  logic [CMP_W-1:0] far_x, far_y;

  // Distance to the nearer edge; outside the frame counts as on the edge
  always_comb begin
    far_x = CMP_W'(FRAME_WIDTH - 1) - CMP_W'(column_i);
    far_y = CMP_W'(FRAME_HEIGHT - 1) - CMP_W'(row_i);
    if (CMP_W'(column_i) >= CMP_W'(FRAME_WIDTH)) begin
      dx_d = '0;
    end else if (CMP_W'(column_i) < far_x) begin
      dx_d = column_i;
    end else begin
      dx_d = far_x[POS_W-1:0];
    end
    if (CMP_W'(row_i) >= CMP_W'(FRAME_HEIGHT)) begin
      dy_d = '0;
    end else if (CMP_W'(row_i) < far_y) begin
      dy_d = row_i;
    end else begin
      dy_d = far_y[POS_W-1:0];
    end
  end

  always_comb begin
    dmin = (dx_q < dy_q) ? dx_q : dy_q;
    if (dmin < POS_W'(BORDER)) begin
      k_d = K_W'(POS_W'(BORDER) - dmin);
    end else begin
      k_d = '0;
    end
    ksq_d = KSQ_W'(k_q) * KSQ_W'(k_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (ctl_i.en[1]) begin
      k_q <= k_d;
    end
    if (ctl_i.en[2]) begin
      ksq_q <= ksq_d;
    end
  end

  assign ksq_o = ksq_q;

endmodule

// ===== design/egd_chan.sv =====
module egd_chan (
  input  logic                        clk_i,
  input  egd_pkg::egd_ctl_t           ctl_i,
  input  logic [egd_pkg::CH_W-1:0]    ch_i,
  input  logic                        mode_i,
  input  logic [egd_pkg::SCALE_W-1:0] scale_i,
  input  logic [egd_pkg::KSQ_W-1:0]   ksq_i,
  output logic [egd_pkg::CH_W-1:0]    ch_o
);
  import egd_pkg::*;

  logic [CH_W-1:0]    c1_q, c2_q, c3_q, c4_q, c5_q;
  logic               m1_q, m2_q, m3_q, m4_q, m5_q;
  logic [SCALE_W-1:0] scale1_q;
  logic [CH_W-1:0]    dark_d, dark2_q, dark3_q, dark4_q, dark5_q;
  logic [CH_W-1:0]    inv3_q;
  logic [NUM_W-1:0]   num4_q, num5_q;
  logic [CH_W-1:0]    qe5_q;
  logic [CH_W-1:0]    out_d, out_q;
  logic [DARK_W-1:0]  dark_prod;
  logic [PROD_W-1:0]  recip_prod;
  logic [NUM_W-1:0]   rem;
  logic               corr;
  logic [CH_W:0]      sum;

  // Darken: round the sixteenths product and clip to full scale
  always_comb begin
    dark_prod = DARK_W'(c1_q) * DARK_W'(scale1_q) + DARK_W'(8);
    if (dark_prod[DARK_W-1:4] > (DARK_W-4)'(CH_MAX)) begin
      dark_d = CH_MAX;
    end else begin
      dark_d = dark_prod[CH_W+3:4];
    end
  end

  // Divide by the border area through its reciprocal; the estimate is low by at most one
  assign recip_prod = PROD_W'(num4_q) * PROD_W'(RECIP);

  always_comb begin
    rem  = num5_q - NUM_W'(qe5_q) * NUM_W'(DEN);
    corr = (rem >= NUM_W'(DEN));
    sum  = (CH_W+1)'(c5_q) + (CH_W+1)'(qe5_q) + (CH_W+1)'(corr);
    if (m5_q == MODE_DARKEN) begin
      out_d = dark5_q;
    end else if (sum > (CH_W+1)'(CH_MAX)) begin
      out_d = CH_MAX;
    end else begin
      out_d = sum[CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      c1_q     <= ch_i;
      m1_q     <= mode_i;
      scale1_q <= scale_i;
    end
    if (ctl_i.en[1]) begin
      c2_q    <= c1_q;
      m2_q    <= m1_q;
      dark2_q <= dark_d;
    end
    if (ctl_i.en[2]) begin
      c3_q    <= c2_q;
      m3_q    <= m2_q;
      dark3_q <= dark2_q;
      inv3_q  <= CH_MAX - c2_q;
    end
    if (ctl_i.en[3]) begin
      c4_q    <= c3_q;
      m4_q    <= m3_q;
      dark4_q <= dark3_q;
      num4_q  <= NUM_W'(inv3_q) * NUM_W'(ksq_i);
    end
    if (ctl_i.en[4]) begin
      c5_q    <= c4_q;
      m5_q    <= m4_q;
      dark5_q <= dark4_q;
      num5_q  <= num4_q;
      qe5_q   <= recip_prod[RECIP_SH +: CH_W];
    end
    if (ctl_i.en[5]) begin
      out_q <= out_d;
    end
  end

  assign ch_o = out_q;

endmodule

// ===== design/rgb555_edge_glow_and_darken_top.sv =====
// Throughput: one word per cycle while the output is not stalled; six register
// stages, each advancing when it is empty or its word moves on, so a stalled
// output holds the run of full stages next to it, while empty stages still fill.
// Reset (rst_ni low, asynchronous): pipeline emptied, effect_mode = glow,
// darken_scale = 10. Configuration writes are always taken.
module rgb555_edge_glow_and_darken_top (
  input logic         clk_i,
  input logic         rst_ni,
  egd_pix_in_if.sink  pix_i,
  egd_pix_out_if.source pix_o,
  egd_cfg_if.sink     cfg_i
);
  import egd_pkg::*;

  logic               mode_q;
  logic [SCALE_W-1:0] scale_q;
  egd_ctl_t           ctl;
  logic [KSQ_W-1:0]   ksq;
  logic [CH_W-1:0]    r_out, g_out, b_out;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_GLOW;
      scale_q <= SCALE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_EFFECT_MODE:  mode_q  <= cfg_i.data[0];
        CFG_DARKEN_SCALE: scale_q <= cfg_i.data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  egd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (pix_o.valid),
    .out_ready_i (pix_o.ready),
    .ctl_o       (ctl)
  );

  egd_pos u_pos (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .column_i (pix_i.column),
    .row_i    (pix_i.row),
    .ksq_o    (ksq)
  );

  egd_chan u_red (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .ch_i    (pix_i.pixel_in[4:0]),
    .mode_i  (mode_q),
    .scale_i (scale_q),
    .ksq_i   (ksq),
    .ch_o    (r_out)
  );

  egd_chan u_green (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .ch_i    (pix_i.pixel_in[9:5]),
    .mode_i  (mode_q),
    .scale_i (scale_q),
    .ksq_i   (ksq),
    .ch_o    (g_out)
  );

  egd_chan u_blue (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .ch_i    (pix_i.pixel_in[14:10]),
    .mode_i  (mode_q),
    .scale_i (scale_q),
    .ksq_i   (ksq),
    .ch_o    (b_out)
  );

  assign pix_o.pixel_out = {1'b1, b_out, g_out, r_out};

endmodule

// ===== design/egd_checker.sv =====
module egd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_pixel_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i
);

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pixel_i))
    else $error("output word changed while stalled");

  // Every result is opaque
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_pixel_i[15])
    else $error("result without alpha bit");

  // Empty output stage never blocks the input
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with output empty");

  // Input stalls only behind a stalled output word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled while output moves");

  // Configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

endmodule

bind rgb555_edge_glow_and_darken_top egd_checker u_egd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_pixel_i (pix_o.pixel_out),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);
